// ----- sv/sec_pkg.sv -----
// shared types and constants for the segment edge crossing block
package sec_pkg;

	localparam int unsigned CoordW  = 24;
	localparam int unsigned DiffW   = 25;
	localparam int unsigned NormW   = 18;
	localparam int unsigned SlackW  = 16;
	localparam int unsigned ProdW   = 52;
	localparam int unsigned FracW   = 32;
	localparam int unsigned SlackReset = 66;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [DiffW-1:0]  diff_t;
	typedef logic signed [NormW-1:0]  norm_t;
	typedef logic        [SlackW-1:0] slack_t;

endpackage

// ----- sv/segment_edge_crossing.sv -----
// pipelined segment versus polygon edge crossing test
// depth: 2 + 3*32 + 17 + 3 = 118 pipeline stages plus the result register
// throughput: one transaction per cycle while out_stall is low; every divide and square root step
// has its own pipeline stage so the pipeline never stalls on its own
// reset: arst_n clears all stage valid bits and loads edge_slack with 66
// a downstream stall freezes the whole pipeline; nothing is lost or repeated
module segment_edge_crossing (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  sec_pkg::coord_t            seg_start_x,
	input  sec_pkg::coord_t            seg_start_y,
	input  sec_pkg::coord_t            seg_end_x,
	input  sec_pkg::coord_t            seg_end_y,
	input  sec_pkg::coord_t            edge_a_x,
	input  sec_pkg::coord_t            edge_a_y,
	input  sec_pkg::coord_t            edge_b_x,
	input  sec_pkg::coord_t            edge_b_y,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  sec_pkg::slack_t            cfg_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       hit,
	output sec_pkg::coord_t            cross_x,
	output sec_pkg::coord_t            cross_y,
	output sec_pkg::norm_t             normal_x,
	output sec_pkg::norm_t             normal_y
);

	// pipeline is a single frozen shift: advance whenever the output is not stalled
	localparam int unsigned NDiv = 32;  // fraction bits of k and of both normal quotients
	localparam int unsigned NSq  = 17;  // root bits, one per stage
	localparam int unsigned NStg = 2 + 3 * NDiv + NSq + 3;
	localparam int unsigned DiffW_l = sec_pkg::DiffW + 1;

	logic adv;
	assign adv       = !out_stall;
	assign in_stall  = out_stall;
	assign cfg_ready = 1'b1;

	sec_pkg::slack_t edge_slack_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_slack_q <= sec_pkg::slack_t'(sec_pkg::SlackReset);
		end else if (cfg_valid) begin
			edge_slack_q <= cfg_data;
		end
	end

	// per item record that travels the whole pipeline
	typedef struct packed {
		logic                                ok;      // still a candidate
		logic signed [sec_pkg::DiffW-1:0]    abx;
		logic signed [sec_pkg::DiffW-1:0]    aby;
		logic signed [sec_pkg::DiffW-1:0]    dx;
		logic signed [sec_pkg::DiffW-1:0]    dy;
		sec_pkg::coord_t                     p1x;
		sec_pkg::coord_t                     p1y;
		sec_pkg::coord_t                     ax;
		sec_pkg::coord_t                     ay;
		logic [sec_pkg::ProdW-1:0]           den;     // -d
		logic [sec_pkg::ProdW:0]             rem;     // k divider remainder
		logic [sec_pkg::FracW:0]             k;
		logic [sec_pkg::ProdW-1:0]           len2;
		logic [sec_pkg::ProdW:0]             rx;      // normal x divider remainder
		logic [sec_pkg::ProdW:0]             ry;
		logic [sec_pkg::FracW:0]             qx;
		logic [sec_pkg::FracW:0]             qy;
		logic [16:0]                         sx;      // square root partials
		logic [16:0]                         sy;
	} item_t;

	logic  vld_q [NStg];
	item_t itm_q [NStg];

	// stage 0: differences
	// stage 1: d and e products, hit pre-test, k integer part, edge length squared, normal divider start
	item_t s0_n, s1_n;
	logic signed [sec_pkg::ProdW-1:0] d1, e1;
	always_comb begin
		s0_n       = '0;
		s0_n.ok    = 1'b1;
		s0_n.abx   = sec_pkg::DiffW'(edge_b_x) - sec_pkg::DiffW'(edge_a_x);
		s0_n.aby   = sec_pkg::DiffW'(edge_b_y) - sec_pkg::DiffW'(edge_a_y);
		s0_n.dx    = sec_pkg::DiffW'(seg_end_x) - sec_pkg::DiffW'(seg_start_x);
		s0_n.dy    = sec_pkg::DiffW'(seg_end_y) - sec_pkg::DiffW'(seg_start_y);
		s0_n.p1x   = seg_start_x;
		s0_n.p1y   = seg_start_y;
		s0_n.ax    = edge_a_x;
		s0_n.ay    = edge_a_y;
	end

	always_comb begin
		logic signed [DiffW_l-1:0] apx, apy;
		s1_n = itm_q[0];
		apx  = DiffW_l'(itm_q[0].p1x) - DiffW_l'(itm_q[0].ax);
		apy  = DiffW_l'(itm_q[0].p1y) - DiffW_l'(itm_q[0].ay);
		d1   = sec_pkg::ProdW'(itm_q[0].abx * itm_q[0].dy)
			 - sec_pkg::ProdW'(itm_q[0].aby * itm_q[0].dx);
		e1   = sec_pkg::ProdW'(itm_q[0].abx * apy) - sec_pkg::ProdW'(itm_q[0].aby * apx);
		s1_n.den  = sec_pkg::ProdW'(-d1);
		s1_n.ok   = (d1 < 0) && (e1 >= 0) && (e1 <= -d1);
		// integer part is 1 only when e equals -d, it ends at bit 32 after the shifts
		s1_n.k    = {32'd0, (e1 == -d1)};
		s1_n.rem  = (e1 == -d1) ? '0 : {1'b0, e1};
		s1_n.len2 = sec_pkg::ProdW'(itm_q[0].abx * itm_q[0].abx)
			  + sec_pkg::ProdW'(itm_q[0].aby * itm_q[0].aby);
		// normal dividers start with c^2 (c^2 <= L so integer part is c^2==L)
		s1_n.rx   = {1'b0, sec_pkg::ProdW'(itm_q[0].aby * itm_q[0].aby)};
		s1_n.ry   = {1'b0, sec_pkg::ProdW'(itm_q[0].abx * itm_q[0].abx)};
		s1_n.qx   = '0;
		s1_n.qy   = '0;
		if (!s1_n.ok) begin
			s1_n.den = 52'd1;
			s1_n.rem = '0;
		end
	end

	// integer part of the normal quotients, folded into stage 1
	// stages 2 .. 2+3*NDiv-1: three divide units stepped in turn, one bit of one unit per stage,
	// each unit's steps spread over three stages in turn to keep the carry chains short
	function automatic item_t div_step(input item_t i, input int unsigned ph);
		item_t o;
		logic [sec_pkg::ProdW:0] t;
		o = i;
		unique case (ph)
			0: begin
				t = {i.rem[sec_pkg::ProdW-1:0], 1'b0};
				o.k = {i.k[sec_pkg::FracW-1:0], (t >= {1'b0, i.den})};
				o.rem = (t >= {1'b0, i.den}) ? t - {1'b0, i.den} : t;
			end
			1: begin
				t = {i.rx[sec_pkg::ProdW-1:0], 1'b0};
				o.qx = {i.qx[sec_pkg::FracW-1:0], (t >= {1'b0, i.len2})};
				o.rx = (t >= {1'b0, i.len2}) ? t - {1'b0, i.len2} : t;
			end
			default: begin
				t = {i.ry[sec_pkg::ProdW-1:0], 1'b0};
				o.qy = {i.qy[sec_pkg::FracW-1:0], (t >= {1'b0, i.len2})};
				o.ry = (t >= {1'b0, i.len2}) ? t - {1'b0, i.len2} : t;
			end
		endcase
		return o;
	endfunction

	// fix integer part of normal quotients before fraction steps
	function automatic item_t norm_int(input item_t i);
		item_t o;
		o = i;
		if (i.len2 == '0) begin
			o.len2 = 52'd1;
			o.rx = '0;
			o.ry = '0;
		end else begin
			if (i.rx[sec_pkg::ProdW-1:0] == i.len2) begin
				o.qx = 33'd1;
				o.rx = '0;
			end
			if (i.ry[sec_pkg::ProdW-1:0] == i.len2) begin
				o.qy = 33'd1;
				o.ry = '0;
			end
		end
		return o;
	endfunction

	// square root step, one root bit per stage, both axes in parallel
	function automatic item_t sqrt_step(input item_t i, input int unsigned b);
		item_t o;
		logic [17:0] tx, ty;
		o  = i;
		tx = {1'b0, i.sx} | (18'd1 << b);
		ty = {1'b0, i.sy} | (18'd1 << b);
		if (36'(tx) * 36'(tx) <= 36'(i.qx)) o.sx = tx[16:0];
		if (36'(ty) * 36'(ty) <= 36'(i.qy)) o.sy = ty[16:0];
		return o;
	endfunction

	localparam int unsigned SqBase = 2 + 3 * NDiv;
	localparam int unsigned LrpBase = SqBase + NSq;

	// tail stages: k*D products, rounding, projection, slack test, normal round
	logic signed [59:0] kdx_n, kdy_n;
	logic signed [59:0] kdx_q, kdy_q;
	logic signed [sec_pkg::DiffW:0] mx_q, my_q;
	logic signed [sec_pkg::ProdW+1:0] proj_q;
	logic signed [sec_pkg::ProdW+1:0] lo_q, hi_q;

	function automatic logic [16:0] rnd(input logic [16:0] r, input logic [sec_pkg::FracW:0] q);
		logic [34:0] rr;
		rr = 35'(r) * 35'(r);
		return (35'(q) - rr > 35'(r)) ? r + 17'd1 : r;
	endfunction

	genvar g;
	generate
		for (g = 0; g < NStg; g++) begin : g_stage
			if (g == 0) begin : g_head
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						vld_q[g] <= 1'b0;
					end else if (adv) begin
						vld_q[g] <= in_valid;
					end
				end
				always_ff @(posedge clk) begin
					if (adv) begin
						itm_q[g] <= s0_n;
					end
				end
			end else begin : g_body
				item_t nxt;
				if (g == 1) begin : g_norm
					assign nxt = norm_int(s1_n);
				end else if (g < SqBase) begin : g_div
					assign nxt = div_step(itm_q[g-1], (g - 2) % 3);
				end else if (g < LrpBase) begin : g_sqrt
					assign nxt = sqrt_step(itm_q[g-1], 16 - (g - SqBase));
				end else begin : g_tail
					assign nxt = itm_q[g-1];
				end
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						vld_q[g] <= 1'b0;
					end else if (adv) begin
						vld_q[g] <= vld_q[g-1];
					end
				end
				always_ff @(posedge clk) begin
					if (adv) begin
						itm_q[g] <= nxt;
					end
				end
			end
		end
	endgenerate

	// lerp and projection on the item at the tail stages
	item_t t0, t1, t2, t3;
	assign t0 = itm_q[LrpBase - 1];
	assign t1 = itm_q[LrpBase];
	assign t2 = itm_q[LrpBase + 1];
	assign t3 = itm_q[LrpBase + 2];
	assign kdx_n = 60'($signed({1'b0, t0.k})) * 60'(t0.dx);
	assign kdy_n = 60'($signed({1'b0, t0.k})) * 60'(t0.dy);

	logic signed [59:0] rxr, ryr;
	assign rxr = kdx_q + 60'sd2147483648;
	assign ryr = kdy_q + 60'sd2147483648;

	logic signed [sec_pkg::DiffW:0] amx, amy;
	assign amx = mx_q - 26'(t2.ax);
	assign amy = my_q - 26'(t2.ay);

	logic [16:0] nxm, nym;
	logic signed [sec_pkg::NormW-1:0] nx_q, ny_q;
	assign nxm = rnd(t2.sx, t2.qx);
	assign nym = rnd(t2.sy, t2.qy);

	always_ff @(posedge clk) begin
		if (adv) begin
			kdx_q  <= kdx_n;
			kdy_q  <= kdy_n;
			mx_q   <= 26'(t1.p1x) + 26'(rxr >>> 32);
			my_q   <= 26'(t1.p1y) + 26'(ryr >>> 32);
			proj_q <= 54'(amx * t2.abx) + 54'(amy * t2.aby);
			lo_q   <= -54'({edge_slack_q, 16'd0});
			hi_q   <= 54'(t2.len2) + 54'({edge_slack_q, 16'd0});
			nx_q   <= (t2.aby > 0) ? -18'(nxm) : 18'(nxm);
			ny_q   <= (t2.abx < 0) ? -18'(nym) : 18'(nym);
		end
	end

	// result register, driven from the last stage
	logic                  hit_n;
	logic signed [25:0]    mx_d_q, my_d_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			mx_d_q <= mx_q;
			my_d_q <= my_q;
		end
	end
	assign hit_n = t3.ok && (proj_q >= lo_q) && (proj_q <= hi_q);

	logic out_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_q[LrpBase + 2];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			hit      <= hit_n;
			cross_x  <= hit_n ? mx_d_q[23:0] : '0;
			cross_y  <= hit_n ? my_d_q[23:0] : '0;
			normal_x <= hit_n ? nx_q : '0;
			normal_y <= hit_n ? ny_q : '0;
		end
	end
	assign out_valid = out_valid_q;

endmodule

// ----- sv/segment_edge_crossing_chk.sv -----
// port level checker for segment_edge_crossing, bound into every segment_edge_crossing instance
module segment_edge_crossing_chk (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic hit,
	input logic [23:0] cross_x,
	input logic [17:0] normal_x,
	input logic [17:0] normal_y
);
	a_stall: assert property (@(posedge clk) disable iff (!arst_n) in_stall == out_stall)
		else $error("input stall differs from output stall");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cross_x))
		else $error("stalled result changed");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> cross_x == 24'd0 && normal_x == 18'd0)
		else $error("miss result not zero");
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> normal_x != 18'd0 || normal_y != 18'd0)
		else $error("hit with zero normal");
endmodule

bind segment_edge_crossing segment_edge_crossing_chk u_chk (.*);
